### design/gsfa_pkg.sv
// ============================================================================
// gsfa_pkg: shared types and constants of the gas sensor frame averager
// Frame layout positions, register indexes, reset values and the
// command/status bundles between the controller and the datapath.
// ============================================================================
package gsfa_pkg;

    // Widths fixed by the field list
    localparam int BYTE_W  = 8;
    localparam int PPM_W   = 16;
    localparam int CFG_W   = 4;
    localparam int POS_W   = 4;
    localparam int INDEX_W = 5;

    // Default for the largest averaging window
    localparam int DEF_MAX_AVERAGE = 8;

    // Byte positions inside a response frame (position 1 follows the start byte)
    localparam logic [POS_W-1:0] POS_IDLE  = 4'd0;
    localparam logic [POS_W-1:0] POS_FIRST = 4'd1;
    localparam logic [POS_W-1:0] POS_HIGH  = 4'd2;
    localparam logic [POS_W-1:0] POS_LOW   = 4'd3;
    localparam logic [POS_W-1:0] POS_SUM_LAST = 4'd7;
    localparam logic [POS_W-1:0] POS_CHECK = 4'd8;

    // Configuration register indexes
    localparam logic CFG_WARMUP  = 1'b0;
    localparam logic CFG_AVERAGE = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] WARMUP_RESET  = 4'd7;
    localparam logic [CFG_W-1:0] AVERAGE_RESET = 4'd4;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // input request taken this cycle
        logic div_run;   // advance the divider one bit
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic has_result; // the offered byte finishes or cuts a frame
        logic need_div;   // that result closes a window with nonzero readings
        logic div_last;   // divider is on its final bit
    } t_dp_status;

endpackage

### design/gas_sensor_frame_averager.sv
// ============================================================================
// gas_sensor_frame_averager: NDIR CO2 sensor response checker and averager
// Frames received UART bytes, verifies each frame checksum and averages
// the readings of each run after a warmup period.
// ============================================================================
// Each input request carries one received byte and a frame start flag. A
// result comes out for every frame that completes (ninth byte) or is cut
// off by a new frame start; bytes outside a frame give nothing. The
// reading that closes an averaging window with at least one nonzero
// reading runs a bit-serial divider over the window sum (21 bits wide for
// MAX_AVERAGE of 8), and no input is taken while it runs; every other byte
// leaves the input free. A result waiting on the output holds all input
// until it is taken.
// The divider is the only iterative unit. Registers: index 0 warmup
// readings (reset 7), index 1 window size (reset 4, 0 acts as 1, larger
// than MAX_AVERAGE clamps to MAX_AVERAGE).
module gas_sensor_frame_averager #(
    parameter int MAX_AVERAGE = gsfa_pkg::DEF_MAX_AVERAGE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_index,
    input  logic [gsfa_pkg::CFG_W-1:0]  i_cfg_data,
    // Byte stream in
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // [7:0] rx_byte
    input  logic                        s_axis_tuser,  // [0] frame_start
    // Result stream out
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,  // [15:0] reading_ppm,
                                                       // [31:16] average_ppm
    output logic [3:0]                  m_axis_tuser   // [0] reading_ok,
                                                       // [1] in_warmup,
                                                       // [2] average_ready,
                                                       // [3] no_valid_reading
);
    import gsfa_pkg::*;

    t_dp_cmd            cmd;
    t_dp_status         status;
    logic [PPM_W-1:0]   reading_ppm;
    logic [PPM_W-1:0]   average_ppm;
    logic               reading_ok;
    logic               in_warmup;
    logic               average_ready;
    logic               no_valid_reading;

    // Sequence requests and the divider
    gsfa_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    // Frame, run and average arithmetic
    gsfa_datapath #(
        .MAX_AVERAGE (MAX_AVERAGE)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_rx_byte          (s_axis_tdata),
        .i_frame_start      (s_axis_tuser),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_reading_ppm      (reading_ppm),
        .o_reading_ok       (reading_ok),
        .o_in_warmup        (in_warmup),
        .o_average_ready    (average_ready),
        .o_average_ppm      (average_ppm),
        .o_no_valid_reading (no_valid_reading)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tdata = {average_ppm, reading_ppm};
    assign m_axis_tuser = {no_valid_reading, average_ready, in_warmup, reading_ok};

endmodule

### design/gsfa_datapath.sv
// ============================================================================
// gsfa_datapath: frame assembly, run bookkeeping and average divider
// Tracks the byte position and checksum of the open frame, the warmup and
// window counters, and holds the result payload. A restoring divider forms
// the window mean one quotient bit per cycle.
// ============================================================================
module gsfa_datapath #(
    parameter int MAX_AVERAGE = gsfa_pkg::DEF_MAX_AVERAGE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_index,
    input  logic [gsfa_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [gsfa_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                          i_frame_start,
    input  gsfa_pkg::t_dp_cmd             i_cmd,
    output gsfa_pkg::t_dp_status          o_status,
    output logic [gsfa_pkg::PPM_W-1:0]    o_reading_ppm,
    output logic                          o_reading_ok,
    output logic                          o_in_warmup,
    output logic                          o_average_ready,
    output logic [gsfa_pkg::PPM_W-1:0]    o_average_ppm,
    output logic                          o_no_valid_reading
);
    import gsfa_pkg::*;

    // A warmup count raised mid-run can stretch a run to this many kept readings
    localparam int KEEP_MAX = (1 << CFG_W) - 1 + MAX_AVERAGE;
    localparam int SUM_W  = $clog2(KEEP_MAX * ((1 << PPM_W) - 1) + 1);
    localparam int CNT_W  = $clog2(KEEP_MAX + 1);
    localparam int DCNT_W = $clog2(SUM_W);
    localparam int CMP_W  = INDEX_W + 1;

    // Configuration
    logic [CFG_W-1:0]   r_warmup;
    logic [CFG_W-1:0]   r_average;

    // Frame state
    logic [POS_W-1:0]   r_pos,  n_pos;
    logic [BYTE_W-1:0]  r_acc,  n_acc;
    logic [BYTE_W-1:0]  r_hi,   n_hi;
    logic [BYTE_W-1:0]  r_lo,   n_lo;

    // Run state
    logic [INDEX_W-1:0] r_idx;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_cnt;

    // Divider
    logic [SUM_W-1:0]   r_div_q,   n_div_q;
    logic [CNT_W-1:0]   r_div_rem, n_div_rem;
    logic [CNT_W-1:0]   r_div_den;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [CNT_W:0]     rem_shift;
    logic               rem_ge;

    // Frame decode
    logic               has_result;
    logic [PPM_W-1:0]   rd_ppm;
    logic               rd_ok;

    // Run decode
    logic               warm;
    logic               nonzero;
    logic [SUM_W-1:0]   sum_add;
    logic [CNT_W-1:0]   cnt_add;
    logic [CMP_W-1:0]   win_size;
    logic               win_end;
    logic               none;
    logic               take;

    always_comb begin
        n_pos      = r_pos;
        n_acc      = r_acc;
        n_hi       = r_hi;
        n_lo       = r_lo;
        has_result = 1'b0;
        rd_ppm     = '0;
        rd_ok      = 1'b0;
        if (i_frame_start) begin
            // Open a new frame; an open one is cut off with a zero reading
            has_result = (r_pos != POS_IDLE);
            n_pos      = POS_FIRST;
            n_acc      = '0;
            n_hi       = '0;
            n_lo       = '0;
        end else if (r_pos != POS_IDLE) begin
            if (r_pos <= POS_SUM_LAST) begin
                n_acc = r_acc + i_rx_byte;
            end
            if (r_pos == POS_HIGH) begin
                n_hi = i_rx_byte;
            end
            if (r_pos == POS_LOW) begin
                n_lo = i_rx_byte;
            end
            if (r_pos == POS_CHECK) begin
                rd_ok      = (BYTE_W'(8'd0 - r_acc) == i_rx_byte);
                rd_ppm     = rd_ok ? {r_hi, r_lo} : '0;
                has_result = 1'b1;
                n_pos      = POS_IDLE;
                n_acc      = '0;
                n_hi       = '0;
                n_lo       = '0;
            end else begin
                n_pos = r_pos + POS_FIRST;
            end
        end
    end

    always_comb begin
        win_size = CMP_W'(r_average);
        if (win_size == '0) begin
            win_size = CMP_W'(1);
        end
        if (win_size > CMP_W'(MAX_AVERAGE)) begin
            win_size = CMP_W'(MAX_AVERAGE);
        end
        warm    = ({1'b0, r_idx} < CMP_W'(r_warmup));
        nonzero = (rd_ppm != '0);
        sum_add = nonzero ? (r_sum + SUM_W'(rd_ppm)) : r_sum;
        cnt_add = nonzero ? (r_cnt + CNT_W'(1)) : r_cnt;
        win_end = !warm && ((CMP_W'(r_idx) + CMP_W'(1)) >= (CMP_W'(r_warmup) + win_size));
        none    = win_end && (cnt_add == '0);
        take    = i_cmd.accept && has_result;
    end

    // Divider step: shift in the next dividend bit, subtract where it fits
    always_comb begin
        rem_shift = {r_div_rem, r_div_q[SUM_W-1]};
        rem_ge    = (rem_shift >= {1'b0, r_div_den});
        n_div_rem = rem_ge ? CNT_W'(rem_shift - {1'b0, r_div_den}) : CNT_W'(rem_shift);
        n_div_q   = {r_div_q[SUM_W-2:0], rem_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup  <= WARMUP_RESET;
            r_average <= AVERAGE_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_WARMUP) begin
                r_warmup <= i_cfg_data;
            end
            if (i_cfg_index == CFG_AVERAGE) begin
                r_average <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_IDLE;
            r_idx <= '0;
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.accept) begin
            r_pos <= n_pos;
            if (has_result) begin
                if (warm) begin
                    r_idx <= r_idx + INDEX_W'(1);
                end else if (win_end) begin
                    r_idx <= '0;
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_idx <= r_idx + INDEX_W'(1);
                    r_sum <= sum_add;
                    r_cnt <= cnt_add;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_acc <= n_acc;
            r_hi  <= n_hi;
            r_lo  <= n_lo;
        end
    end

    // Result payload and divider operands
    always_ff @(posedge i_clk) begin
        if (take) begin
            o_reading_ppm      <= rd_ppm;
            o_reading_ok       <= rd_ok;
            o_in_warmup        <= warm;
            o_average_ready    <= win_end;
            o_no_valid_reading <= none;
            o_average_ppm      <= '0;
            r_div_q            <= sum_add;
            r_div_den          <= cnt_add;
            r_div_rem          <= '0;
            r_dcnt             <= DCNT_W'(SUM_W - 1);
        end else if (i_cmd.div_run) begin
            r_div_q   <= n_div_q;
            r_div_rem <= n_div_rem;
            r_dcnt    <= r_dcnt - DCNT_W'(1);
            if (r_dcnt == '0) begin
                o_average_ppm <= n_div_q[PPM_W-1:0];
            end
        end
    end

    assign o_status.has_result = has_result;
    assign o_status.need_div   = has_result && win_end && !none;
    assign o_status.div_last   = (r_dcnt == '0);

endmodule

### design/gsfa_ctrl.sv
// ============================================================================
// gsfa_ctrl: handshake and sequencing controller
// Accepts input requests, starts the divider when a window closes with
// nonzero readings, and owns the result valid flag.
// ============================================================================
module gsfa_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  gsfa_pkg::t_dp_status  i_status,
    output gsfa_pkg::t_dp_cmd     o_cmd
);
    import gsfa_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;

    logic r_state,     n_state;
    logic r_out_valid, n_out_valid;
    logic accept;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;

    assign o_cmd.accept  = accept;
    assign o_cmd.div_run = (r_state == S_DIV);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !m_axis_tready;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_status.has_result) begin
                    if (i_status.need_div) begin
                        n_state = S_DIV;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !s_axis_tready)
        else $error("input request taken while dividing");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_status.has_result && i_status.need_div)
        |=> (r_state == S_DIV) && !r_out_valid)
        else $error("window close did not start the divider");

    a_div_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_status.div_last) |=> (r_state == S_IDLE) && r_out_valid)
        else $error("divider end did not post the result");

    a_no_div_while_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !r_out_valid)
        else $error("result pending during division");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: gas sensor frame averager
// Sends sensor response frames (good, bad checksum, cut off, and loose
// bytes) through the byte stream under several warmup and window settings,
// predicts every reading and window average, and checks each result.
// ============================================================================
module testbench;

    import gsfa_pkg::*;

    localparam int WINDOW_MAX   = DEF_MAX_AVERAGE;
    localparam int FRAME_BYTES  = 9;
    localparam int BYTE_TARGET  = 1300;
    localparam int SETTLE_TICKS = 30;      // one divide plus margin
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 40;

    typedef logic [BYTE_W-1:0] t_frame [FRAME_BYTES];

    // One result of the block, field by field
    typedef struct {
        logic [PPM_W-1:0] reading_ppm;
        logic             reading_ok;
        logic             in_warmup;
        logic             average_ready;
        logic [PPM_W-1:0] average_ppm;
        logic             no_valid_reading;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        s_axis_tuser;   // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [15:0] reading_ppm, [31:16] average_ppm
    logic [3:0]  m_axis_tuser;   // [0] reading_ok, [1] in_warmup,
                                 // [2] average_ready, [3] no_valid_reading

    gas_sensor_frame_averager #(
        .MAX_AVERAGE(WINDOW_MAX)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: registers, open frame and averaging run
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   warmup_setting;
    logic [CFG_W-1:0]   window_setting;
    logic [POS_W-1:0]   frame_pos;
    logic [BYTE_W-1:0]  frame_sum;
    logic [BYTE_W-1:0]  ppm_hi_byte;
    logic [BYTE_W-1:0]  ppm_lo_byte;
    logic [INDEX_W-1:0] run_index;
    int                 run_sum;
    int                 run_nonzero;

    t_reading expected_readings[$];

    bit stalls_on;
    int error_count;
    int bytes_sent;
    int readings_checked;
    int averages_seen;
    int empty_windows;
    int warmup_readings;
    int cycle_count;

    // Feed one reading into the run and queue the result it gives
    task automatic queue_reading(input logic [PPM_W-1:0] ppm, input logic ok);
        t_reading r;
        int span;
        int kept;
        r.reading_ppm      = ppm;
        r.reading_ok       = ok;
        r.in_warmup        = 1'b0;
        r.average_ready    = 1'b0;
        r.average_ppm      = '0;
        r.no_valid_reading = 1'b0;
        span = (window_setting == 0) ? 1 :
               (window_setting > WINDOW_MAX) ? WINDOW_MAX : int'(window_setting);
        if (run_index < warmup_setting) begin
            r.in_warmup = 1'b1;
            run_index   = run_index + 1'b1;
        end else begin
            kept = int'(run_index) - int'(warmup_setting);
            if (ppm != 0) begin
                run_sum     = run_sum + int'(ppm);
                run_nonzero = run_nonzero + 1;
            end
            if (kept + 1 >= span) begin
                r.average_ready = 1'b1;
                if (run_nonzero == 0)
                    r.no_valid_reading = 1'b1;
                else
                    r.average_ppm = PPM_W'(run_sum / run_nonzero);
                run_index   = '0;
                run_sum     = 0;
                run_nonzero = 0;
            end else begin
                run_index = run_index + 1'b1;
            end
        end
        expected_readings.push_back(r);
    endtask

    // Advance the frame tracker by one accepted byte
    task automatic predict_byte(input logic [BYTE_W-1:0] rx, input logic start);
        logic             cut;
        logic             ok;
        logic [PPM_W-1:0] ppm;
        if (start) begin
            cut         = (frame_pos != POS_IDLE);
            frame_sum   = '0;
            ppm_hi_byte = '0;
            ppm_lo_byte = '0;
            frame_pos   = POS_FIRST;
            if (cut)
                queue_reading('0, 1'b0);
        end else if (frame_pos != POS_IDLE && frame_pos < FRAME_BYTES) begin
            if (frame_pos <= POS_SUM_LAST)
                frame_sum = frame_sum + rx;
            if (frame_pos == POS_HIGH)
                ppm_hi_byte = rx;
            if (frame_pos == POS_LOW)
                ppm_lo_byte = rx;
            if (frame_pos == POS_CHECK) begin
                ok          = (BYTE_W'(8'h00 - frame_sum) == rx);
                ppm         = ok ? {ppm_hi_byte, ppm_lo_byte} : '0;
                frame_pos   = POS_IDLE;
                frame_sum   = '0;
                ppm_hi_byte = '0;
                ppm_lo_byte = '0;
                queue_reading(ppm, ok);
            end else begin
                frame_pos = frame_pos + 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h (cycle %0d)",
                     what, got, want, cycle_count);
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest
    // expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("unexpected result", int'(m_axis_tdata), 0);
            end else begin
                want = expected_readings.pop_front();
                readings_checked++;
                if (want.average_ready)
                    averages_seen++;
                if (want.no_valid_reading)
                    empty_windows++;
                if (want.in_warmup)
                    warmup_readings++;
                if (m_axis_tdata[15:0] !== want.reading_ppm)
                    report_mismatch("reading_ppm", int'(m_axis_tdata[15:0]),
                                    int'(want.reading_ppm));
                if (m_axis_tuser[0] !== want.reading_ok)
                    report_mismatch("reading_ok", int'(m_axis_tuser[0]),
                                    int'(want.reading_ok));
                if (m_axis_tuser[1] !== want.in_warmup)
                    report_mismatch("in_warmup", int'(m_axis_tuser[1]),
                                    int'(want.in_warmup));
                if (m_axis_tuser[2] !== want.average_ready)
                    report_mismatch("average_ready", int'(m_axis_tuser[2]),
                                    int'(want.average_ready));
                if (m_axis_tdata[31:16] !== want.average_ppm)
                    report_mismatch("average_ppm", int'(m_axis_tdata[31:16]),
                                    int'(want.average_ppm));
                if (m_axis_tuser[3] !== want.no_valid_reading)
                    report_mismatch("no_valid_reading", int'(m_axis_tuser[3]),
                                    int'(want.no_valid_reading));
            end
        end
    end

    // Receiver: stall about a quarter of the cycles while stalls are enabled
    always @(negedge i_clk) begin
        m_axis_tready <= !stalls_on || ($urandom_range(0, 99) >= 25);
    end

    // Watchdog: end a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_readings.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving helpers (all enter and leave at a falling edge)
    // ------------------------------------------------------------------

    // Send one request; leave tvalid high so a following byte can go back to back
    task automatic send_byte(input logic [BYTE_W-1:0] rx, input logic start);
        if (stalls_on && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_byte(rx, start);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Hold input until every expected result is out, then let the block settle
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    // Write one register; call only with the block idle
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_WARMUP)
            warmup_setting = val;
        else
            window_setting = val;
        @(negedge i_clk);
    endtask

    // Build a response frame with a matching check byte
    function automatic t_frame make_frame(input logic [BYTE_W-1:0] cmd,
                                          input logic [PPM_W-1:0] ppm,
                                          input logic [31:0] filler);
        t_frame f;
        logic [BYTE_W-1:0] sum;
        f[0] = 8'hFF;
        f[1] = cmd;
        f[2] = ppm[15:8];
        f[3] = ppm[7:0];
        f[4] = filler[7:0];
        f[5] = filler[15:8];
        f[6] = filler[23:16];
        f[7] = filler[31:24];
        sum = '0;
        for (int i = 1; i <= 7; i++)
            sum = sum + f[i];
        f[8] = 8'h00 - sum;
        return f;
    endfunction

    // Send the first n bytes of a frame, frame start on the first
    task automatic send_frame(input t_frame f, input int n);
        for (int i = 0; i < n; i++)
            send_byte(f[i], i == 0);
    endtask

    function automatic logic [PPM_W-1:0] pick_ppm();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return PPM_W'($urandom_range(300, 5000));
            default: return PPM_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Random content frame, bad check byte about one time in five
    task automatic send_sensor_frame();
        t_frame f;
        f = make_frame(8'h86, pick_ppm(), $urandom());
        if ($urandom_range(0, 4) == 0)
            f[8] = f[8] ^ BYTE_W'($urandom_range(1, 255));
        send_frame(f, FRAME_BYTES);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked frames around each corner of the framing and averaging
    task automatic test_directed_frames();
        t_frame f;
        write_reg(CFG_WARMUP, 4'd0);
        write_reg(CFG_AVERAGE, 4'd2);
        // loose bytes with no frame open: drop
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // largest reading, then an all-zero frame whose check byte is 0
        send_frame(make_frame(8'h86, 16'hFFFF, 32'h0), FRAME_BYTES);
        send_frame(make_frame(8'h00, 16'h0000, 32'h0), FRAME_BYTES);
        // two cut-off frames back to back close a window with no valid reading
        f = make_frame(8'h86, 16'h04D2, 32'h5A5A_A5A5);
        send_frame(f, 3);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        // bad checksum frame cuts the open one; trailing byte is dropped
        f = make_frame(8'h86, 16'h0190, 32'hFFFF_FFFF);
        f[8] = f[8] ^ 8'h01;
        send_frame(f, FRAME_BYTES);
        send_byte(8'hA5, 1'b0);
        wait_drain();
    endtask

    // Run frames under extreme and clamped warmup and window settings
    task automatic test_window_settings();
        logic [CFG_W-1:0] warm_list [6];
        logic [CFG_W-1:0] span_list [6];
        int span;
        warm_list = '{4'd0, 4'd15, 4'd15, 4'd0, 4'd3, 4'd1};
        span_list = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd9, 4'd3};
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_WARMUP, warm_list[p]);
            write_reg(CFG_AVERAGE, span_list[p]);
            span = (span_list[p] == 0) ? 1 :
                   (span_list[p] > WINDOW_MAX) ? WINDOW_MAX : int'(span_list[p]);
            repeat (int'(warm_list[p]) + 2 * span) send_sensor_frame();
            wait_drain();
        end
    endtask

    // Mostly well-formed frames with random content, mixed with cut-off frames,
    // garbage frames and loose bytes; settings sometimes change between bursts
    task automatic test_random_traffic();
        t_frame f;
        int pick;
        int burst_end;
        int first_byte;
        first_byte = bytes_sent;
        while (bytes_sent < BYTE_TARGET) begin
            // keep a long stretch with no idling on either side
            stalls_on = (bytes_sent - first_byte) >= 100;
            burst_end = bytes_sent + $urandom_range(60, 140);
            while (bytes_sent < burst_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 72) begin
                    f = make_frame(($urandom_range(0, 3) == 0) ? BYTE_W'($urandom()) : 8'h86,
                                   pick_ppm(), $urandom());
                    if ($urandom_range(0, 1) == 0)
                        f[0] = BYTE_W'($urandom());
                    if (pick >= 60)
                        f[8] = f[8] ^ BYTE_W'($urandom_range(1, 255));
                    send_frame(f, FRAME_BYTES);
                end else if (pick < 82) begin
                    f = make_frame(8'h86, pick_ppm(), $urandom());
                    send_frame(f, $urandom_range(1, FRAME_BYTES - 1));
                end else if (pick < 92) begin
                    send_byte(BYTE_W'($urandom()), $urandom_range(0, 3) == 0);
                end else begin
                    for (int i = 0; i < FRAME_BYTES; i++)
                        f[i] = BYTE_W'($urandom());
                    send_frame(f, FRAME_BYTES);
                end
            end
            // hold the sender until all results are out, sometimes retune
            wait_drain();
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_WARMUP, CFG_W'($urandom_range(0, 4)));
                write_reg(CFG_AVERAGE, CFG_W'($urandom_range(0, 15)));
            end
        end
        stalls_on = 1'b1;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = CFG_WARMUP;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        m_axis_tready  = 1'b0;
        stalls_on      = 1'b1;
        warmup_setting = WARMUP_RESET;
        window_setting = AVERAGE_RESET;
        frame_pos      = POS_IDLE;
        frame_sum      = '0;
        ppm_hi_byte    = '0;
        ppm_lo_byte    = '0;
        run_index      = '0;
        run_sum        = 0;
        run_nonzero    = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values first: a few frames under warmup 7, window 4
        repeat (12) send_sensor_frame();
        wait_drain();

        test_directed_frames();
        test_window_settings();
        test_random_traffic();

        wait_drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (expected_readings.size() != 0)
            report_mismatch("results never delivered", expected_readings.size(), 0);

        $display("covered %0d sensor bytes, %0d readings checked (%0d in warmup)",
                 bytes_sent, readings_checked, warmup_readings);
        $display("covered %0d window averages, %0d of them with no valid reading",
                 averages_seen, empty_windows);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
